### rtl/wera_pkg.sv
// Package with shared constants and codes for the windowed error-rate averager.
`default_nettype none
package wera_pkg;
    localparam int HISTORY_DEPTH      = 64;
    localparam int RATE_FRACTION_BITS = 16;
    localparam int TIME_W             = 32;
    localparam int KIND_W             = 2;
    localparam int STATUS_W           = 2;
    localparam logic [31:0] WINDOW_RESET = 32'd60;

    localparam logic [KIND_W-1:0] KIND_RECORD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FRAMES = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ORDER     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;
endpackage
`default_nettype wire

### rtl/wera_if.sv
// Request, response and configuration channel interfaces.
`default_nettype none
interface wera_req_if;
    logic                            valid;
    logic                            ready;
    logic [wera_pkg::KIND_W-1:0]     kind;
    logic [wera_pkg::TIME_W-1:0]     time_stamp;
    logic [31:0]                     frames_total;
    logic [31:0]                     lost_total;
    modport source (output valid, kind, time_stamp, frames_total, lost_total, input ready);
    modport sink   (input valid, kind, time_stamp, frames_total, lost_total, output ready);
endinterface

interface wera_rsp_if #(parameter int RATE_W = wera_pkg::RATE_FRACTION_BITS + 1);
    logic                            valid;
    logic                            ready;
    logic [wera_pkg::STATUS_W-1:0]   status;
    logic [RATE_W-1:0]               error_rate;
    modport source (output valid, status, error_rate, input ready);
    modport sink   (input valid, status, error_rate, output ready);
endinterface

interface wera_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### rtl/windowed_error_rate_averager.sv
// Top level: windowed error-rate averager with history RAM and shared divider.
//
//  channel  dir  payload                                        accepted when
//  i_req    in   kind, time_stamp, frames_total, lost_total     valid && ready
//  o_rsp    out  status, error_rate                             valid && ready
//  i_cfg    in   data (window_length)                           valid && ready
//
// One request is handled at a time; ready is high only while idle.
// A record that is written passes through decode, the divider when it runs, and the history write.
// A query reads, evaluates and accumulates each entry walked, then runs the divider if one fell in the window.
// Reset is synchronous and empties the history; stored entries need no clearing.
// A response waits in its register until taken; no new request is taken meanwhile.
`default_nettype none
module windowed_error_rate_averager #(
    parameter int HISTORY_DEPTH      = wera_pkg::HISTORY_DEPTH,
    parameter int RATE_FRACTION_BITS = wera_pkg::RATE_FRACTION_BITS
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    wera_req_if.sink   i_req,
    wera_rsp_if.source o_rsp,
    wera_cfg_if.sink   i_cfg
);
    localparam int F      = RATE_FRACTION_BITS;
    localparam int RATE_W = F + 1;
    localparam int AW     = $clog2(HISTORY_DEPTH);
    localparam int CW     = $clog2(HISTORY_DEPTH + 1);
    localparam int MEM_W  = 32 + RATE_W;
    localparam int NW     = 33 + F;
    localparam int DCW    = $clog2(NW + 1);
    localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(1) << F;
    localparam logic [AW-1:0]     LAST_SLOT = AW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0]     FULL_CNT  = CW'(HISTORY_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_REC_WR, S_Q_RD, S_Q_EV, S_Q_ACC, S_Q_END, S_DIV, S_OUT
    } t_state;

    t_state r_state;
    logic [wera_pkg::KIND_W-1:0] r_kind;
    logic [31:0] r_t, r_frames, r_lost, r_window, r_prev_frames, r_prev_lost;
    logic [31:0] r_newest_stamp, r_last, r_div;
    logic [AW-1:0] r_newest, r_slot;
    logic [CW-1:0] r_count, r_idx;
    logic signed [32:0] r_start;
    logic [NW-1:0] r_num, r_sum;
    logic [32:0] r_rem;
    logic [RATE_W-1:0] r_quot, r_rate;
    logic [DCW-1:0] r_dcnt;
    logic [RATE_W+31:0] r_prod;
    logic r_take, r_found, r_is_query, r_out_valid;
    logic [wera_pkg::STATUS_W-1:0] r_status;

    logic [MEM_W-1:0] rd_data;
    logic [31:0] rd_stamp, n_w, dl, df;
    logic [RATE_W-1:0] rd_rate;
    logic [AW-1:0] n_wr_slot, n_next_slot;
    logic [AW+1:0] oldest_wide;
    logic [32:0] rem_sh;
    logic div_ge, wr_en;

    assign rd_stamp = rd_data[MEM_W-1:RATE_W];
    assign rd_rate  = rd_data[RATE_W-1:0];
    assign n_next_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + AW'(1);
    assign rem_sh = {r_rem[31:0], r_num[NW-1]};
    assign div_ge = rem_sh >= {1'b0, r_div};
    assign dl = (r_lost > r_prev_lost) ? r_lost - r_prev_lost : 32'd0;
    assign df = r_frames - r_prev_frames;
    assign oldest_wide = (AW+2)'(r_newest) + (AW+2)'(HISTORY_DEPTH)
                       - (AW+2)'(r_count - CW'(1));
    assign wr_en = (r_state == S_REC_WR);

    always_comb begin
        n_wr_slot = r_newest;
        if (r_count != '0 && r_t != r_newest_stamp) begin
            n_wr_slot = (r_newest == LAST_SLOT) ? '0 : r_newest + AW'(1);
        end
        if (r_found) begin
            n_w = rd_stamp - r_last;
        end else begin
            n_w = 32'($signed({1'b0, rd_stamp}) - r_start);
        end
    end

    wera_ram #(.WIDTH(MEM_W), .DEPTH(HISTORY_DEPTH)) u_hist (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(n_wr_slot),
        .i_wdata({r_t, r_rate}),
        .i_raddr(r_slot),
        .o_rdata(rd_data)
    );

    assign i_req.ready      = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.error_rate = r_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_window      <= wera_pkg::WINDOW_RESET;
            r_prev_frames <= '0;
            r_prev_lost   <= '0;
            r_newest      <= '0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_window <= i_cfg.data;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_kind   <= i_req.kind;
                        r_t      <= i_req.time_stamp;
                        r_frames <= i_req.frames_total;
                        r_lost   <= i_req.lost_total;
                        r_state  <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_status <= wera_pkg::ST_OK;
                    r_rate   <= '0;
                    r_state  <= S_OUT;
                    case (r_kind)
                        wera_pkg::KIND_RECORD: begin
                            if (r_count != '0 && r_t < r_newest_stamp) begin
                                r_status <= wera_pkg::ST_ORDER;
                            end else if (r_frames <= r_prev_frames) begin
                                r_status <= wera_pkg::ST_NO_FRAMES;
                                r_state  <= S_REC_WR;
                            end else if (dl >= df) begin
                                r_rate  <= RATE_ONE;
                                r_state <= S_REC_WR;
                            end else begin
                                r_num      <= {1'b0, dl, {F{1'b0}}};
                                r_div      <= df;
                                r_rem      <= '0;
                                r_dcnt     <= DCW'(NW);
                                r_is_query <= 1'b0;
                                r_state    <= S_DIV;
                            end
                        end
                        wera_pkg::KIND_QUERY: begin
                            r_start <= $signed({1'b0, r_t}) - $signed({1'b0, r_window});
                            r_slot  <= (oldest_wide >= (AW+2)'(HISTORY_DEPTH))
                                     ? AW'(oldest_wide - (AW+2)'(HISTORY_DEPTH))
                                     : AW'(oldest_wide);
                            r_idx   <= '0;
                            r_sum   <= '0;
                            r_found <= 1'b0;
                            if (r_count == '0) begin
                                r_status <= wera_pkg::ST_EMPTY;
                            end else begin
                                r_state <= S_Q_RD;
                            end
                        end
                        wera_pkg::KIND_CLEAR: begin
                            r_count <= '0;
                        end
                        default: begin
                        end
                    endcase
                end
                S_REC_WR: begin
                    if (r_count == '0) begin
                        r_count <= CW'(1);
                    end else if (r_t != r_newest_stamp && r_count < FULL_CNT) begin
                        r_count <= r_count + CW'(1);
                    end
                    r_newest       <= n_wr_slot;
                    r_newest_stamp <= r_t;
                    r_prev_frames  <= r_frames;
                    r_prev_lost    <= r_lost;
                    r_state        <= S_OUT;
                end
                S_Q_RD: begin
                    r_state <= S_Q_EV;
                end
                S_Q_EV: begin
                    r_take <= 1'b0;
                    if (rd_stamp > r_t) begin
                        r_state <= S_Q_END;
                    end else begin
                        if ($signed({1'b0, rd_stamp}) > r_start) begin
                            r_prod  <= rd_rate * n_w;
                            r_last  <= rd_stamp;
                            r_found <= 1'b1;
                            r_take  <= 1'b1;
                        end
                        r_state <= S_Q_ACC;
                    end
                end
                S_Q_ACC: begin
                    if (r_take) begin
                        r_sum <= r_sum + NW'(r_prod);
                    end
                    r_idx  <= r_idx + CW'(1);
                    r_slot <= n_next_slot;
                    r_state <= (r_idx + CW'(1) == r_count) ? S_Q_END : S_Q_RD;
                end
                S_Q_END: begin
                    if (!r_found) begin
                        r_status <= wera_pkg::ST_EMPTY;
                        r_state  <= S_OUT;
                    end else begin
                        r_num      <= r_sum;
                        r_div      <= 32'($signed({1'b0, r_last}) - r_start);
                        r_rem      <= '0;
                        r_dcnt     <= DCW'(NW);
                        r_is_query <= 1'b1;
                        r_state    <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_dcnt == '0) begin
                        r_rate  <= r_quot;
                        r_state <= r_is_query ? S_OUT : S_REC_WR;
                    end else begin
                        r_rem  <= div_ge ? rem_sh - {1'b0, r_div} : rem_sh;
                        r_num  <= {r_num[NW-2:0], 1'b0};
                        r_quot <= {r_quot[RATE_W-2:0], div_ge};
                        r_dcnt <= r_dcnt - DCW'(1);
                    end
                end
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                    end else if (o_rsp.ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/wera_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wera_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/wera_checker.sv
// Port-level checker for the windowed error-rate averager, with its bind.
`default_nettype none
module wera_checker #(
    parameter int RATE_FRACTION_BITS = wera_pkg::RATE_FRACTION_BITS
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              i_in_ready,
    input wire logic                              i_out_valid,
    input wire logic                              i_out_ready,
    input wire logic [wera_pkg::STATUS_W-1:0]     i_status,
    input wire logic [RATE_FRACTION_BITS:0]       i_rate
);
    localparam logic [RATE_FRACTION_BITS:0] ONE = (RATE_FRACTION_BITS+1)'(1) << RATE_FRACTION_BITS;

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready) else $error("ready after request");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready |-> !i_out_valid) else $error("ready while response pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid) else $error("response dropped");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_rate <= ONE) else $error("rate above one");
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != wera_pkg::ST_OK |-> i_rate == '0) else $error("flag with rate");
endmodule

bind windowed_error_rate_averager wera_checker #(.RATE_FRACTION_BITS(RATE_FRACTION_BITS)) u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_req.valid),
    .i_in_ready (i_req.ready),
    .i_out_valid(o_rsp.valid),
    .i_out_ready(o_rsp.ready),
    .i_status   (o_rsp.status),
    .i_rate     (o_rsp.error_rate)
);
`default_nettype wire
